// ===== src/lse_pkg.sv =====
`default_nettype none
package lse_pkg;

  localparam int MAGIC_CHARS = 2;
  localparam int MagicBits   = MAGIC_CHARS * 8;
  localparam int LenBits     = 32;
  localparam int ByteBits    = 8;
  localparam int CntBits     = 5;

  localparam logic [15:0] MAGIC_RESET  = 16'd0;
  localparam logic [7:0]  HEADER_RESET = 8'd54;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_MAGIC  = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_EXT    = 3'd3,
    PH_PAYLEN = 3'd4,
    PH_PAY    = 3'd5,
    PH_IDLE   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_EXT      = 2'd0,
    KIND_PAY      = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_DONE     = 2'd3
  } kind_t;

  typedef enum logic {
    REG_MAGIC  = 1'b0,
    REG_HEADER = 1'b1
  } reg_idx_t;

  localparam logic [CntBits-1:0] MAGIC_LAST = CntBits'(MagicBits - 1);
  localparam logic [CntBits-1:0] LEN_LAST   = CntBits'(LenBits - 1);
  localparam logic [CntBits-1:0] BYTE_LAST  = CntBits'(ByteBits - 1);

endpackage
`default_nettype wire

// ===== src/lse_if.sv =====
`default_nettype none
interface lse_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] stego_byte;
  logic       first_byte;
  modport source (output valid, output stego_byte, output first_byte, input ready);
  modport sink (input valid, input stego_byte, input first_byte, output ready);
endinterface

interface lse_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;
  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

interface lse_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/lsb_stego_extractor_core.sv =====
// a result passes through the input register and the result register after the transfer of the byte that completes it
// throughput: one carrier byte per cycle while no stalled result holds the result register,
//   set by the single decode pass between the input register and the result register
// reset: synchronous, clears phase, counters and pending items; magic_value returns
//   to 0 and header_length to 54
`default_nettype none
module lsb_stego_extractor_core (
  input  wire           clk,
  input  wire           rst,
  lse_pixel_if.sink     pixel,
  lse_result_if.source  result,
  lse_cfg_if.sink       cfg
);
  import lse_pkg::*;

  logic [15:0] magic_value;
  logic [7:0]  header_length;

  logic        in_valid;
  logic        in_bit;
  logic        in_first;

  phase_t               phase, phase_next;
  logic [7:0]           header_count, header_count_next;
  logic [CntBits-1:0]   bit_count, bit_count_next;
  logic [LenBits-1:0]   bit_shift, bit_shift_next;
  logic [LenBits-1:0]   remaining_count, remaining_count_next;

  logic        out_valid;
  logic [7:0]  out_byte;
  kind_t       out_kind;
  logic        out_last;

  logic        res_valid;
  logic [7:0]  res_byte;
  kind_t       res_kind;
  logic        res_last;

  logic        advance;

  phase_t               ph;
  logic [7:0]           hc;
  logic [CntBits-1:0]   bc;
  logic [LenBits-1:0]   sh;
  logic [LenBits-1:0]   rc;
  logic [LenBits-1:0]   gathered;
  logic [LenBits-1:0]   rc_dec;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign pixel.ready  = !in_valid || advance;
  assign cfg.ready    = 1'b1;

  assign result.valid    = out_valid;
  assign result.out_byte = out_byte;
  assign result.kind     = out_kind;
  assign result.last     = out_last;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value   <= MAGIC_RESET;
      header_length <= HEADER_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (reg_idx_t'(cfg.index))
        REG_MAGIC:  magic_value   <= cfg.data;
        REG_HEADER: header_length <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixel.ready) begin
      in_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      in_bit   <= pixel.stego_byte[0];
      in_first <= pixel.first_byte;
    end
  end

  // decode pass
  always_comb begin
    ph = in_first ? PH_HEADER : phase;
    hc = in_first ? 8'd0 : header_count;
    bc = in_first ? '0 : bit_count;
    sh = in_first ? '0 : bit_shift;
    rc = in_first ? '0 : remaining_count;

    phase_next           = ph;
    header_count_next    = hc;
    bit_count_next       = bc;
    bit_shift_next       = sh;
    remaining_count_next = rc;
    res_valid            = 1'b0;
    res_byte             = 8'd0;
    res_kind             = KIND_EXT;
    res_last             = 1'b0;

    if (ph == PH_HEADER && hc >= header_length) begin
      ph         = PH_MAGIC;
      phase_next = PH_MAGIC;
      bc         = '0;
      sh         = '0;
    end

    gathered = {sh[LenBits-2:0], in_bit};
    rc_dec   = rc - LenBits'(1);

    bit_count_next = bc + CntBits'(1);
    bit_shift_next = gathered;

    unique case (ph)
      PH_HEADER: begin
        header_count_next = hc + 8'd1;
        bit_count_next    = bc;
        bit_shift_next    = sh;
      end
      PH_MAGIC: begin
        if (bc == MAGIC_LAST) begin
          bit_count_next = '0;
          bit_shift_next = '0;
          if (gathered[MagicBits-1:0] != MagicBits'(magic_value)) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res_kind   = KIND_MISMATCH;
            res_last   = 1'b1;
          end else begin
            phase_next = PH_EXTLEN;
          end
        end
      end
      PH_EXTLEN: begin
        if (bc == LEN_LAST) begin
          bit_count_next       = '0;
          bit_shift_next       = '0;
          remaining_count_next = gathered;
          phase_next           = (gathered == '0) ? PH_PAYLEN : PH_EXT;
        end
      end
      PH_EXT: begin
        if (bc == BYTE_LAST) begin
          bit_count_next       = '0;
          bit_shift_next       = '0;
          remaining_count_next = rc_dec;
          phase_next           = (rc_dec == '0) ? PH_PAYLEN : PH_EXT;
          res_valid            = 1'b1;
          res_byte             = gathered[7:0];
          res_kind             = KIND_EXT;
        end
      end
      PH_PAYLEN: begin
        if (bc == LEN_LAST) begin
          bit_count_next       = '0;
          bit_shift_next       = '0;
          remaining_count_next = gathered;
          if (gathered == '0) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res_kind   = KIND_DONE;
            res_last   = 1'b1;
          end else begin
            phase_next = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        if (bc == BYTE_LAST) begin
          bit_count_next       = '0;
          bit_shift_next       = '0;
          remaining_count_next = rc_dec;
          phase_next           = (rc_dec == '0) ? PH_IDLE : PH_PAY;
          res_valid            = 1'b1;
          res_byte             = gathered[7:0];
          res_kind             = KIND_PAY;
          res_last             = (rc_dec == '0);
        end
      end
      default: begin
        bit_count_next = bc;
        bit_shift_next = sh;
      end
    endcase
  end

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= 8'd0;
      bit_count       <= '0;
      bit_shift       <= '0;
      remaining_count <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      bit_count       <= bit_count_next;
      bit_shift       <= bit_shift_next;
      remaining_count <= remaining_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_byte <= res_byte;
      out_kind <= res_kind;
      out_last <= res_last;
    end
  end

endmodule
`default_nettype wire

// ===== src/lse_checker.sv =====
`default_nettype none
module lse_checker (
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire [1:0] out_kind,
  input wire       out_last
);
  import lse_pkg::*;

  // nothing offered straight after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result offered after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind)
      && $stable(out_last))
    else $error("stalled result changed");

  // mismatch and done carry last and a zero byte
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_MISMATCH || out_kind == KIND_DONE)
      |-> out_last && out_byte == 8'd0)
    else $error("status result malformed");

  // extension characters never end the stream
  a_ext_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_EXT |-> !out_last)
    else $error("extension character marked last");

endmodule

bind lsb_stego_extractor_core lse_checker u_lse_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_byte  (result.out_byte),
  .out_kind  (result.kind),
  .out_last  (result.last)
);
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import lse_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int NO_CUT = 1 << 30;

  typedef struct {
    logic [7:0] data;
    logic       first;
  } carrier_t;

  typedef struct {
    logic [7:0] val;
    kind_t      kind;
    logic       last;
  } decoded_t;

  logic clk;
  logic rst;

  lse_pixel_if  pixel();
  lse_result_if result();
  lse_cfg_if    cfg();

  lsb_stego_extractor_core DUT (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .result (result),
    .cfg    (cfg)
  );

  carrier_t carrier_q[$];
  decoded_t decoded_q[$];
  carrier_t drv_item;
  decoded_t chk_item;

  // decoder shadow state
  phase_t      dec_phase;
  logic [7:0]  dec_hdr_cnt;
  int          dec_bit_cnt;
  logic [31:0] dec_shift;
  logic [31:0] dec_remain;
  logic [15:0] cur_magic;
  logic [7:0]  cur_hdr_len;

  // stimulus side
  logic [15:0] stim_magic;
  logic [7:0]  stim_hdr;
  logic        fb_next;
  int          budget;
  int          sent_n;
  int          got_n;
  int          hold_cnt;
  int          err_n;
  int          cycle;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  assign calm = (cycle >= 2500) && (cycle < 3500);

  function automatic void next_field(phase_t p);
    dec_phase   = p;
    dec_bit_cnt = 0;
    dec_shift   = '0;
  endfunction

  function automatic bit gather_bit(logic b, int need);
    int n;
    dec_shift = {dec_shift[30:0], b};
    n = dec_bit_cnt + 1;
    if (n >= need) begin
      dec_bit_cnt = 0;
      return 1'b1;
    end
    dec_bit_cnt = n;
    return 1'b0;
  endfunction

  function automatic void expect_out(logic [7:0] v, kind_t k, logic l);
    decoded_t d;
    d.val  = v;
    d.kind = k;
    d.last = l;
    decoded_q.push_back(d);
  endfunction

  function automatic void decode_carrier(logic [7:0] b, logic first);
    logic [31:0] mask;
    mask = (MagicBits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << MagicBits) - 32'd1);
    if (first) begin
      dec_hdr_cnt = '0;
      dec_remain  = '0;
      next_field(PH_HEADER);
    end
    if (dec_phase == PH_HEADER) begin
      if (dec_hdr_cnt < cur_hdr_len) begin
        dec_hdr_cnt = dec_hdr_cnt + 8'd1;
        return;
      end
      next_field(PH_MAGIC);
    end
    case (dec_phase)
      PH_MAGIC: begin
        if (gather_bit(b[0], MagicBits)) begin
          if (dec_shift != (32'(cur_magic) & mask)) begin
            next_field(PH_IDLE);
            expect_out(8'd0, KIND_MISMATCH, 1'b1);
          end else begin
            next_field(PH_EXTLEN);
          end
        end
      end
      PH_EXTLEN: begin
        if (gather_bit(b[0], LenBits)) begin
          dec_remain = dec_shift;
          next_field(dec_remain == 0 ? PH_PAYLEN : PH_EXT);
        end
      end
      PH_EXT: begin
        if (gather_bit(b[0], ByteBits)) begin
          expect_out(dec_shift[7:0], KIND_EXT, 1'b0);
          dec_remain = dec_remain - 32'd1;
          next_field(dec_remain == 0 ? PH_PAYLEN : PH_EXT);
        end
      end
      PH_PAYLEN: begin
        if (gather_bit(b[0], LenBits)) begin
          dec_remain = dec_shift;
          if (dec_remain == 0) begin
            next_field(PH_IDLE);
            expect_out(8'd0, KIND_DONE, 1'b1);
          end else begin
            next_field(PH_PAY);
          end
        end
      end
      PH_PAY: begin
        if (gather_bit(b[0], ByteBits)) begin
          expect_out(dec_shift[7:0], KIND_PAY, dec_remain == 32'd1);
          dec_remain = dec_remain - 32'd1;
          next_field(dec_remain == 0 ? PH_IDLE : PH_PAY);
        end
      end
      default: ;
    endcase
  endfunction

  // carrier byte sender; also decodes each accepted byte into the expected results
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel.valid && pixel.ready) begin
        decode_carrier(pixel.stego_byte, pixel.first_byte);
      end
      if (!pixel.valid || pixel.ready) begin
        if (carrier_q.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
          drv_item = carrier_q.pop_front();
          pixel.valid      <= 1'b1;
          pixel.stego_byte <= drv_item.data;
          pixel.first_byte <= drv_item.first;
        end else begin
          pixel.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) begin
        got_n = got_n + 1;
        if (got_n == 25) begin
          hold_cnt = 300;
        end
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected transfer: got byte %02h kind %0d last %0b",
                   $time, result.out_byte, result.kind, result.last);
          err_n = err_n + 1;
        end else begin
          chk_item = decoded_q.pop_front();
          if (result.out_byte !== chk_item.val || result.kind !== chk_item.kind ||
              result.last !== chk_item.last) begin
            $display("%0t: expected byte %02h kind %0d last %0b, got %02h kind %0d last %0b",
                     $time, chk_item.val, chk_item.kind, chk_item.last,
                     result.out_byte, result.kind, result.last);
            err_n = err_n + 1;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= calm || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  task automatic push_raw(logic [7:0] b);
    carrier_t c;
    if (budget > 0) begin
      c.data  = b;
      c.first = fb_next;
      carrier_q.push_back(c);
      fb_next = 1'b0;
      budget  = budget - 1;
      sent_n  = sent_n + 1;
    end
  endtask

  task automatic push_bits(logic [31:0] v, int n);
    logic [7:0] b;
    for (int i = n - 1; i >= 0; i--) begin
      b = 8'($urandom_range(0, 255));
      b[0] = v[i];
      push_raw(b);
    end
  endtask

  task automatic push_image(logic restart, int hdr_n, logic [15:0] magic,
                            logic [31:0] ext_len, logic [31:0] pay_len, int cut);
    logic [7:0] b;
    fb_next = restart;
    budget  = cut;
    repeat (hdr_n) push_raw(8'($urandom_range(0, 255)));
    push_bits(32'(magic), MagicBits);
    push_bits(ext_len, LenBits);
    for (longint i = 0; i < ext_len && budget > 0; i++) begin
      push_bits($urandom_range(0, 255), ByteBits);
    end
    push_bits(pay_len, LenBits);
    for (longint i = 0; i < pay_len && budget > 0; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_bits(32'(b), ByteBits);
    end
  endtask

  task automatic push_noise(int n, int first_pct);
    budget = NO_CUT;
    repeat (n) begin
      fb_next = ($urandom_range(0, 99) < first_pct);
      push_raw(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic rand_image();
    int          r;
    logic [15:0] m;
    logic [31:0] el;
    logic [31:0] pl;
    r  = $urandom_range(0, 99);
    m  = stim_magic;
    if ($urandom_range(0, 99) >= 85) begin
      m = stim_magic ^ (16'd1 << $urandom_range(0, 15));
    end
    el = $urandom_range(0, 3);
    pl = $urandom_range(0, 8);
    if (r < 70) begin
      push_image(1'b1, stim_hdr, m, el, pl, NO_CUT);
      push_noise($urandom_range(0, 3), 0);
    end else if (r < 88) begin
      if ($urandom_range(0, 1)) begin
        el = $urandom;
      end else begin
        pl = $urandom;
      end
      push_image(1'b1, stim_hdr, m, el, pl, $urandom_range(1, int'(stim_hdr) + 120));
    end else begin
      push_noise($urandom_range(1, 20), 10);
    end
  endtask

  task automatic drain();
    while (carrier_q.size() != 0 || pixel.valid || decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_MAGIC) begin
      cur_magic = val;
    end else begin
      cur_hdr_len = val[7:0];
    end
  endtask

  initial begin
    int phase_no;
    int target;
    int phase_end;

    rst              = 1'b1;
    pixel.valid      = 1'b0;
    pixel.stego_byte = 8'd0;
    pixel.first_byte = 1'b0;
    result.ready     = 1'b0;
    cfg.valid        = 1'b0;
    cfg.index        = REG_MAGIC;
    cfg.data         = 16'd0;
    cycle            = 0;
    sent_n           = 0;
    got_n            = 0;
    hold_cnt         = 0;
    err_n            = 0;
    fb_next          = 1'b0;
    budget           = NO_CUT;
    cur_magic        = MAGIC_RESET;
    cur_hdr_len      = HEADER_RESET;
    stim_magic       = MAGIC_RESET;
    stim_hdr         = HEADER_RESET;
    dec_hdr_cnt      = '0;
    dec_remain       = '0;
    next_field(PH_HEADER);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // decoding straight out of reset, no restart mark
    push_image(1'b0, HEADER_RESET, MAGIC_RESET, 1, 2, NO_CUT);
    push_image(1'b1, HEADER_RESET, MAGIC_RESET, 0, 0, NO_CUT);
    drain();

    write_reg(REG_MAGIC, 16'hA5C3);
    write_reg(REG_HEADER, 16'd0);
    push_image(1'b1, 0, 16'hA5C3, 0, 1, NO_CUT);
    push_image(1'b1, 0, 16'h5A3C, 2, 1, NO_CUT);
    push_noise(5, 0);
    push_image(1'b1, 0, 16'hA5C3, 2, 3, NO_CUT);
    push_noise(4, 0);
    drain();

    // header length lowered part way through the skip
    write_reg(REG_HEADER, 16'd6);
    push_image(1'b1, 3, 16'hA5C3, 0, 0, 3);
    drain();
    write_reg(REG_HEADER, 16'd2);
    push_image(1'b0, 0, 16'hA5C3, 1, 2, NO_CUT);
    drain();

    write_reg(REG_MAGIC, 16'hFFFF);
    write_reg(REG_HEADER, 16'd255);
    push_image(1'b1, 255, 16'hFFFF, 1, 1, NO_CUT);
    drain();

    phase_no = 0;
    target   = 1750;
    while (sent_n < target) begin
      case (phase_no % 4)
        0:       stim_magic = 16'hFFFF;
        1:       stim_magic = 16'h0000;
        default: stim_magic = 16'($urandom_range(0, 65535));
      endcase
      if (phase_no == 2) begin
        stim_hdr = 8'd255;
      end else if (phase_no % 3 == 0) begin
        stim_hdr = 8'd0;
      end else begin
        stim_hdr = 8'($urandom_range(1, 12));
      end
      write_reg(REG_MAGIC, stim_magic);
      write_reg(REG_HEADER, {8'd0, stim_hdr});
      phase_end = sent_n + 250;
      while (sent_n < phase_end && sent_n < target) rand_image();
      drain();
      phase_no = phase_no + 1;
    end

    repeat (20) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
      err_n = err_n + 1;
    end
    if (err_n == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
